// ===== hdl/rmq_pkg.sv =====
// shared constants and types for the rotation matrix to quaternion pipeline
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int TR_W      = IN_W + 2;
	localparam int SUM_W     = IN_W + 1;
	localparam int MAG_W     = IN_W + 1;
	// signed root argument: three diagonal terms plus one
	localparam int ARG_W     = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
	localparam int V_W       = ARG_W - 1 + FRAC_BITS;
	localparam int SQ_W      = (V_W + 1) / 2;
	localparam int REM_W     = SQ_W + 3;
	localparam int NUM_W     = ((MAG_W + FRAC_BITS + 1 > SQ_W + 1) ?
		MAG_W + FRAC_BITS + 1 : SQ_W + 1) + 1;
	localparam int DEN_W     = SQ_W + 2;
	// smallest root is 2^(FRAC_BITS/2), so the divisor is at least this power of two
	localparam int DMIN_LOG  = FRAC_BITS / 2 + 2;
	localparam int QUO_W     = NUM_W - DMIN_LOG;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic  trace_pos;
		logic  degen;
		axis_t axis;
	} side_t;

endpackage

// ===== hdl/rmq_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rmq_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rmq_pkg::NUM_W-1:0] num,
	input  logic [rmq_pkg::DEN_W-1:0] den,
	output logic [rmq_pkg::QUO_W-1:0] quo
);
	import rmq_pkg::*;

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];

	logic [DEN_W-1:0] rem_d [QUO_W];
	logic [QUO_W-1:0] low_d [QUO_W];
	logic [QUO_W-1:0] quo_d [QUO_W];
	logic [DEN_W-1:0] den_d [QUO_W];

	always_comb begin
		logic [DEN_W-1:0] prem;
		logic [QUO_W-1:0] plow;
		logic [QUO_W-1:0] pq;
		logic [DEN_W-1:0] pd;
		logic [DEN_W:0]   rsh;
		logic             qbit;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				// top bits are always below the divisor
				prem = DEN_W'(num[NUM_W-1:QUO_W]);
				plow = num[QUO_W-1:0];
				pq   = '0;
				pd   = den;
			end else begin
				prem = rem_s[k-1];
				plow = low_s[k-1];
				pq   = quo_s[k-1];
				pd   = den_s[k-1];
			end
			rsh  = {prem, plow[QUO_W-1]};
			qbit = (rsh >= {1'b0, pd});
			rem_d[k] = qbit ? DEN_W'(rsh - {1'b0, pd}) : DEN_W'(rsh);
			low_d[k] = plow << 1;
			quo_d[k] = {pq[QUO_W-2:0], qbit};
			den_d[k] = pd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				rem_s[k] <= rem_d[k];
				low_s[k] <= low_d[k];
				quo_s[k] <= quo_d[k];
				den_s[k] <= den_d[k];
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation matrix to unit quaternion, fully pipelined
//
//  channel | signals                                   | direction
//  input   | in_valid in_ready m00..m22                | into block
//  output  | out_valid out_ready quat_x..quat_w degen. | out of block
//
// one matrix per cycle while no result waits for out_ready; out_valid rises once the
// item has passed the stage 1 and 2 registers, the one-bit-per-stage square root
// chain, the stage 4 register, the divider chain and the output register (inputs Q2.14).
// arst_n clears only the valid bits of every stage.
// the whole pipeline holds while a result waits for out_ready; in_ready
// drops in that cycle, so nothing is lost or repeated.
module rotation_matrix_to_quaternion (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [rmq_pkg::IN_W-1:0] m00,
	input  logic signed [rmq_pkg::IN_W-1:0] m01,
	input  logic signed [rmq_pkg::IN_W-1:0] m02,
	input  logic signed [rmq_pkg::IN_W-1:0] m10,
	input  logic signed [rmq_pkg::IN_W-1:0] m11,
	input  logic signed [rmq_pkg::IN_W-1:0] m12,
	input  logic signed [rmq_pkg::IN_W-1:0] m20,
	input  logic signed [rmq_pkg::IN_W-1:0] m21,
	input  logic signed [rmq_pkg::IN_W-1:0] m22,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             quat_x,
	output logic signed [15:0]             quat_y,
	output logic signed [15:0]             quat_z,
	output logic signed [15:0]             quat_w,
	output logic                           degenerate
);
	import rmq_pkg::*;

	localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) <<< FRAC_BITS;

	logic en;

	// stage 1: trace and largest diagonal
	logic                    vld_s1;
	logic signed [IN_W-1:0]  a_s1 [9];
	logic signed [TR_W-1:0]  trace_s1;
	axis_t                   axis_s1;

	// stage 2: root argument and off-diagonal sums
	logic                    vld_s2;
	logic [2*SQ_W-1:0]       v_s2;
	logic signed [SUM_W-1:0] d_s2 [3];
	side_t                   side_s2;

	// stage 3: square root steps
	logic [SQ_W-1:0]         vld_s3;
	logic [REM_W-1:0]        rem_s3  [SQ_W];
	logic [SQ_W-1:0]         root_s3 [SQ_W];
	logic [2*SQ_W-1:0]       v_s3    [SQ_W];
	logic signed [SUM_W-1:0] d_s3    [SQ_W][3];
	side_t                   side_s3 [SQ_W];

	logic [REM_W-1:0]        rem_d  [SQ_W];
	logic [SQ_W-1:0]         root_d [SQ_W];
	logic [2*SQ_W-1:0]       v_d    [SQ_W];

	// stage 4: divider operands
	logic                    vld_s4;
	logic [NUM_W-1:0]        num_s4 [3];
	logic [2:0]              neg_s4;
	logic [DEN_W-1:0]        den_s4;
	logic [SQ_W-2:0]         half_s4;
	side_t                   side_s4;

	// stage 5: sideband alongside the dividers
	logic [QUO_W-1:0]        vld_s5;
	logic [2:0]              neg_s5  [QUO_W];
	logic [SQ_W-2:0]         half_s5 [QUO_W];
	side_t                   side_s5 [QUO_W];
	logic [QUO_W-1:0]        quo    [3];

	// stage 6: output register
	logic                    vld_s6;
	logic signed [15:0]      qx_s6, qy_s6, qz_s6, qw_s6;
	logic                    degen_s6;

	assign en       = !vld_s6 || out_ready;
	assign in_ready = en;

	// stage 1 logic
	logic signed [IN_W-1:0] a_in [9];
	logic signed [TR_W-1:0] trace_d;
	axis_t                  axis_d;

	always_comb begin
		a_in[0] = m00; a_in[1] = m01; a_in[2] = m02;
		a_in[3] = m10; a_in[4] = m11; a_in[5] = m12;
		a_in[6] = m20; a_in[7] = m21; a_in[8] = m22;
		trace_d = TR_W'(m00) + TR_W'(m11) + TR_W'(m22);
		if (m00 < m11) begin
			axis_d = (m11 < m22) ? AX_Z : AX_Y;
		end else begin
			axis_d = (m00 < m22) ? AX_Z : AX_X;
		end
	end

	// stage 2 logic
	logic signed [ARG_W-1:0] arg_d;
	logic signed [SUM_W-1:0] d_d [3];
	side_t                   side_d;
	logic [2*SQ_W-1:0]       v_d2;

	always_comb begin
		logic signed [ARG_W-1:0] e00, e11, e22;
		e00 = ARG_W'(a_s1[0]);
		e11 = ARG_W'(a_s1[4]);
		e22 = ARG_W'(a_s1[8]);
		side_d.trace_pos = (trace_s1 > 0);
		side_d.axis      = axis_s1;
		if (side_d.trace_pos) begin
			arg_d  = ARG_W'(trace_s1) + ONE;
			d_d[0] = SUM_W'(a_s1[7]) - SUM_W'(a_s1[5]);
			d_d[1] = SUM_W'(a_s1[2]) - SUM_W'(a_s1[6]);
			d_d[2] = SUM_W'(a_s1[3]) - SUM_W'(a_s1[1]);
		end else begin
			case (axis_s1)
				AX_Y: begin
					arg_d  = e11 - e22 - e00 + ONE;
					d_d[0] = SUM_W'(a_s1[2]) - SUM_W'(a_s1[6]);
					d_d[1] = SUM_W'(a_s1[7]) + SUM_W'(a_s1[5]);
					d_d[2] = SUM_W'(a_s1[1]) + SUM_W'(a_s1[3]);
				end
				AX_Z: begin
					arg_d  = e22 - e00 - e11 + ONE;
					d_d[0] = SUM_W'(a_s1[3]) - SUM_W'(a_s1[1]);
					d_d[1] = SUM_W'(a_s1[2]) + SUM_W'(a_s1[6]);
					d_d[2] = SUM_W'(a_s1[5]) + SUM_W'(a_s1[7]);
				end
				default: begin
					arg_d  = e00 - e11 - e22 + ONE;
					d_d[0] = SUM_W'(a_s1[7]) - SUM_W'(a_s1[5]);
					d_d[1] = SUM_W'(a_s1[3]) + SUM_W'(a_s1[1]);
					d_d[2] = SUM_W'(a_s1[6]) + SUM_W'(a_s1[2]);
				end
			endcase
		end
		side_d.degen = !side_d.trace_pos && (arg_d <= 0);
		// a non-positive argument is replaced by zero so the root stays zero; those outputs are cleared later
		v_d2 = side_d.degen ? '0 :
			(2*SQ_W)'({arg_d[ARG_W-2:0], {FRAC_BITS{1'b0}}});
	end

	// square root, one result bit per stage
	always_comb begin
		logic [REM_W-1:0]  prem;
		logic [SQ_W-1:0]   proot;
		logic [2*SQ_W-1:0] pv;
		logic [REM_W-1:0]  rsh;
		logic [REM_W-1:0]  trial;
		for (int k = 0; k < SQ_W; k++) begin
			if (k == 0) begin
				prem  = '0;
				proot = '0;
				pv    = v_s2;
			end else begin
				prem  = rem_s3[k-1];
				proot = root_s3[k-1];
				pv    = v_s3[k-1];
			end
			rsh   = {prem[REM_W-3:0], pv[2*SQ_W-1 -: 2]};
			trial = REM_W'({proot, 2'b01});
			if (rsh >= trial) begin
				rem_d[k]  = rsh - trial;
				root_d[k] = {proot[SQ_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = rsh;
				root_d[k] = {proot[SQ_W-2:0], 1'b0};
			end
			v_d[k] = pv << 2;
		end
	end

	// divider operands: round(mag * 2^F / (2 root)) = (mag * 2^(F+1) + 2 root) / (4 root)
	logic [SQ_W-1:0]  root_fin;
	logic [NUM_W-1:0] num_d [3];
	logic [2:0]       neg_d;

	assign root_fin = root_s3[SQ_W-1];

	always_comb begin
		logic [MAG_W-1:0] mag;
		for (int c = 0; c < 3; c++) begin
			neg_d[c] = d_s3[SQ_W-1][c] < 0;
			mag      = neg_d[c] ? MAG_W'(-d_s3[SQ_W-1][c]) : MAG_W'(d_s3[SQ_W-1][c]);
			num_d[c] = (NUM_W'(mag) << (FRAC_BITS + 1)) + (NUM_W'(root_fin) << 1);
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		rmq_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[c]),
			.den (den_s4),
			.quo (quo[c])
		);
	end

	// output saturation and component placement
	function automatic logic signed [15:0] sat_quo(input logic neg, input logic [QUO_W-1:0] q);
		logic [63:0] qe;
		qe = 64'(q);
		if (neg) begin
			sat_quo = (qe > 64'd32768) ? -16'sd32768 : 16'(-qe);
		end else begin
			sat_quo = (qe > 64'd32767) ? 16'sd32767 : 16'(qe);
		end
	endfunction

	logic signed [15:0] c_q [3];
	logic signed [15:0] h_q;
	logic signed [15:0] qx_d, qy_d, qz_d, qw_d;
	side_t              side_fin;

	assign side_fin = side_s5[QUO_W-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			c_q[c] = sat_quo(neg_s5[QUO_W-1][c], quo[c]);
		end
		h_q = (32'(half_s5[QUO_W-1]) > 32'd32767) ? 16'sd32767 :
			16'(half_s5[QUO_W-1]);
		if (side_fin.degen) begin
			qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
		end else if (side_fin.trace_pos) begin
			qx_d = c_q[0]; qy_d = c_q[1]; qz_d = c_q[2]; qw_d = h_q;
		end else begin
			case (side_fin.axis)
				AX_Y: begin
					qy_d = h_q; qw_d = c_q[0]; qz_d = c_q[1]; qx_d = c_q[2];
				end
				AX_Z: begin
					qz_d = h_q; qw_d = c_q[0]; qx_d = c_q[1]; qy_d = c_q[2];
				end
				default: begin
					qx_d = h_q; qw_d = c_q[0]; qy_d = c_q[1]; qz_d = c_q[2];
				end
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= '0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= {vld_s3[SQ_W-2:0], vld_s2};
			vld_s4 <= vld_s3[SQ_W-1];
			vld_s5 <= {vld_s5[QUO_W-2:0], vld_s4};
			vld_s6 <= vld_s5[QUO_W-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a_in;
			trace_s1 <= trace_d;
			axis_s1  <= axis_d;

			v_s2    <= v_d2;
			d_s2    <= d_d;
			side_s2 <= side_d;

			for (int k = 0; k < SQ_W; k++) begin
				rem_s3[k]  <= rem_d[k];
				root_s3[k] <= root_d[k];
				v_s3[k]    <= v_d[k];
			end
			d_s3[0]    <= d_s2;
			side_s3[0] <= side_s2;
			for (int k = 1; k < SQ_W; k++) begin
				d_s3[k]    <= d_s3[k-1];
				side_s3[k] <= side_s3[k-1];
			end

			num_s4  <= num_d;
			neg_s4  <= neg_d;
			den_s4  <= DEN_W'(root_fin) << 2;
			half_s4 <= root_fin[SQ_W-1:1];
			side_s4 <= side_s3[SQ_W-1];

			neg_s5[0]  <= neg_s4;
			half_s5[0] <= half_s4;
			side_s5[0] <= side_s4;
			for (int k = 1; k < QUO_W; k++) begin
				neg_s5[k]  <= neg_s5[k-1];
				half_s5[k] <= half_s5[k-1];
				side_s5[k] <= side_s5[k-1];
			end

			qx_s6    <= qx_d;
			qy_s6    <= qy_d;
			qz_s6    <= qz_d;
			qw_s6    <= qw_d;
			degen_s6 <= side_fin.degen;
		end
	end

	assign out_valid  = vld_s6;
	assign quat_x     = qx_s6;
	assign quat_y     = qy_s6;
	assign quat_z     = qz_s6;
	assign quat_w     = qw_s6;
	assign degenerate = degen_s6;

endmodule

// ===== hdl/rmq_check.sv =====
// port-level checks for the quaternion pipeline, bound to the top level
module rmq_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [15:0]              quat_x,
	input logic signed [15:0]              quat_y,
	input logic signed [15:0]              quat_z,
	input logic signed [15:0]              quat_w,
	input logic                            degenerate
);

	// a waiting result stays until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_y)
			&& $stable(quat_z) && $stable(quat_w) && $stable(degenerate))
		else $error("output changed while stalled");

	// a stalled output freezes the pipeline, so no new item may enter
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0
			&& quat_w == 0)
		else $error("degenerate result not zeroed");

	// a valid root is at least 2^(FRAC_BITS/2) in raw units, so its half is nonzero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> quat_x != 0 || quat_y != 0 || quat_z != 0
			|| quat_w != 0)
		else $error("non-degenerate result is all zero");

endmodule

bind rotation_matrix_to_quaternion rmq_check u_rmq_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.quat_x     (quat_x),
	.quat_y     (quat_y),
	.quat_z     (quat_z),
	.quat_w     (quat_w),
	.degenerate (degenerate)
);
